>>> rtl/mdbe_pkg.sv
`timescale 1ns / 1ps
package mdbe_pkg;
  localparam int PT_W   = 16;
  localparam int AREA_W = 16;
  localparam int RHO_W  = 24;
  localparam int LEX_W  = 4;
  localparam logic [RHO_W-1:0] RHO_MAX = {RHO_W{1'b1}};
  // density divider quotient width: pt << 14 over area
  localparam int NUM_W  = PT_W + 14;
endpackage

>>> rtl/median_density_background_estimator.sv
`timescale 1ns / 1ps
// Median jet density background estimator.
// in_ channel: one word per jet, tdata = {jet_area, jet_pt}, tlast marks the
// final jet of an event. A stored jet passes through the accept, the
// divider start, 30 restoring divider steps and the memory write.
// A jet that arrives with the store full (MAX_JETS) is dropped and
// flags overflow; if it carries tlast it still closes the event.
// After the last jet each stored jet is ranked against all others by
// momentum, and the kept ones are marked in memory. The two middle
// densities are then found by counting, for each kept jet, the kept jets
// below it; a jet that is not kept is skipped.
// out_ channel: one word per event, tdata = rho, tuser = {overflow,
// rho_valid}. The result register holds while out_tready is low; the next
// event loads meanwhile, but its result waits until the old word is taken.
// cfg_we writes lead_exclude (reset 2); the user must write it only while
// no event is in flight, as the block itself does not enforce it.
// Reset (rst_n low, synchronous) empties the event and the result register;
// memory is not cleared, entries above the jet count are never read.
module median_density_background_estimator #(
  parameter int MAX_JETS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // jet_pt[15:0], jet_area[31:16]
  input  logic        in_tlast,   // last_jet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // rho[23:0]
  output logic [1:0]  out_tuser,  // rho_valid[0], overflow[1]
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata   // lead_exclude
);
  import mdbe_pkg::*;
  localparam int AW = $clog2(MAX_JETS);
  localparam int CW = $clog2(MAX_JETS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RANK_I, S_RANK_IW, S_RANK_JA, S_RANK_JD,
    S_SEL_K, S_SEL_KW, S_SEL_JA, S_SEL_JD, S_FIN
  } state_t;

  // one memory word per stored jet; keep marks a jet that enters the median
  typedef struct packed {
    logic             keep;
    logic [RHO_W-1:0] dens;
    logic [PT_W-1:0]  pt;
  } jet_word_t;

  state_t state_r;

  logic [LEX_W-1:0]  lex_r;
  logic [CW-1:0]     cnt_r;
  logic              ovf_r, last_r;
  logic [AW-1:0]     i_r, j_r, k_r;
  logic [CW-1:0]     rank_r, m_r, lt_r;
  jet_word_t         cur_r;
  logic [RHO_W-1:0]  lo_r, hi_r;
  logic [PT_W-1:0]   jpt_r;
  logic [AREA_W-1:0] jar_r;
  logic              div_go_r;
  logic              out_vld_r, out_ok_r, out_ovf_r;
  logic [RHO_W-1:0]  out_rho_r;

  // memory and divider
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  jet_word_t         mem_wd, mem_rd;
  logic              div_done;
  logic [RHO_W-1:0]  div_q;

  logic              above, below, j_last, k_last, i_last, keep_nxt, fin_load;
  logic [CW-1:0]     rank_nxt, lt_nxt, tgt_lo, tgt_hi, cnt_m1;
  logic [RHO_W:0]    mid_sum;

  mdbe_ram #(.WIDTH($bits(jet_word_t)), .DEPTH(MAX_JETS)) u_mem (
    .clk, .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .raddr(mem_ra), .rdata(mem_rd));
  mdbe_div u_div (.clk, .rst_n, .start(div_go_r), .pt(jpt_r), .area(jar_r),
    .done(div_done), .dens(div_q));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_rho_r;
  assign out_tuser  = {out_ovf_r, out_ok_r};

  // compares for the rank and select sweeps
  always_comb begin
    cnt_m1   = cnt_r - CW'(1);
    j_last   = (CW'(j_r) == cnt_m1);
    k_last   = (CW'(k_r) == cnt_m1);
    i_last   = (CW'(i_r) == cnt_m1);
    // jet j ranks above jet i: larger pt, or equal pt and earlier
    above    = (mem_rd.pt > cur_r.pt) || (mem_rd.pt == cur_r.pt && j_r < i_r);
    // kept jet j sorts below candidate k; index breaks ties
    below    = mem_rd.keep && ((mem_rd.dens < cur_r.dens) ||
               (mem_rd.dens == cur_r.dens && j_r < k_r));
    rank_nxt = rank_r + CW'(above);
    lt_nxt   = lt_r + CW'(below);
    keep_nxt = (rank_nxt >= CW'(lex_r));
    tgt_lo   = (m_r - CW'(1)) >> 1;
    tgt_hi   = m_r >> 1;
    mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
    fin_load = (state_r == S_FIN) && (!out_vld_r || out_tready);
  end

  // write port: new jet from the divider, keep flag after ranking
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r[AW-1:0];
    mem_wd = '{keep: 1'b0, dens: div_q, pt: jpt_r};
    if (state_r == S_RANK_JD && j_last) begin
      mem_we = 1'b1;
      mem_wa = i_r;
      mem_wd = '{keep: keep_nxt, dens: cur_r.dens, pt: cur_r.pt};
    end else if (state_r == S_DIV && div_done) begin
      mem_we = 1'b1;
    end
  end

  // read port
  always_comb begin
    case (state_r)
      S_RANK_I: mem_ra = i_r;
      S_SEL_K:  mem_ra = k_r;
      default:  mem_ra = j_r;
    endcase
  end

  always_ff @(posedge clk) begin
    div_go_r <= rst_n && in_tvalid && (state_r == S_IDLE) && (cnt_r < CW'(MAX_JETS));
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lex_r     <= LEX_W'(2);
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) lex_r <= cfg_wdata;
      out_vld_r <= fin_load || (out_vld_r && !out_tready);
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          last_r <= in_tlast;
          jpt_r  <= in_tdata[15:0];
          jar_r  <= in_tdata[31:16];
          if (cnt_r < CW'(MAX_JETS)) begin
            state_r <= S_DIV;
          end else begin
            ovf_r <= 1'b1;
            if (in_tlast) begin
              i_r <= '0; m_r <= '0;
              state_r <= S_RANK_I;
            end
          end
        end
        S_DIV: if (div_done) begin
          cnt_r <= cnt_r + CW'(1);
          if (last_r) begin
            i_r <= '0; m_r <= '0;
            state_r <= S_RANK_I;
          end else begin
            state_r <= S_IDLE;
          end
        end
        // rank jet i against every stored jet
        S_RANK_I: state_r <= S_RANK_IW;
        S_RANK_IW: begin
          cur_r   <= mem_rd;
          j_r     <= '0;
          rank_r  <= '0;
          state_r <= S_RANK_JA;
        end
        S_RANK_JA: state_r <= S_RANK_JD;
        S_RANK_JD: begin
          rank_r <= rank_nxt;
          if (j_last) begin
            if (keep_nxt) m_r <= m_r + CW'(1);
            if (i_last) begin
              k_r <= '0;
              state_r <= S_SEL_K;
            end else begin
              i_r <= i_r + AW'(1);
              state_r <= S_RANK_I;
            end
          end else begin
            j_r <= j_r + AW'(1);
            state_r <= S_RANK_JA;
          end
        end
        // each kept candidate: count kept jets below it
        S_SEL_K: state_r <= S_SEL_KW;
        S_SEL_KW: begin
          cur_r <= mem_rd;
          j_r   <= '0;
          lt_r  <= '0;
          if (mem_rd.keep) begin
            state_r <= S_SEL_JA;
          end else if (k_last) begin
            state_r <= S_FIN;
          end else begin
            k_r <= k_r + AW'(1);
            state_r <= S_SEL_K;
          end
        end
        S_SEL_JA: state_r <= S_SEL_JD;
        S_SEL_JD: begin
          lt_r <= lt_nxt;
          if (j_last) begin
            if (lt_nxt == tgt_lo) lo_r <= cur_r.dens;
            if (lt_nxt == tgt_hi) hi_r <= cur_r.dens;
            if (k_last) begin
              state_r <= S_FIN;
            end else begin
              k_r <= k_r + AW'(1);
              state_r <= S_SEL_K;
            end
          end else begin
            j_r <= j_r + AW'(1);
            state_r <= S_SEL_JA;
          end
        end
        // load the result once the previous word is gone
        S_FIN: if (fin_load) begin
          out_rho_r <= (m_r == '0) ? '0 : mid_sum[RHO_W:1];
          out_ok_r  <= (m_r != '0);
          out_ovf_r <= ovf_r;
          cnt_r     <= '0;
          ovf_r     <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_JETS)) else $error("jet count past capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider done outside a jet load");
endmodule

>>> rtl/mdbe_ram.sv
`timescale 1ns / 1ps
module mdbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/mdbe_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; saturates to RHO_MAX.
module mdbe_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [mdbe_pkg::PT_W-1:0]   pt,
  input  logic [mdbe_pkg::AREA_W-1:0] area,
  output logic done,
  output logic [mdbe_pkg::RHO_W-1:0]  dens
);
  import mdbe_pkg::*;
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [AREA_W:0]   rem_r, rem_nxt;
  logic [AREA_W-1:0] den_r;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic [AREA_W:0]   sh;

  always_comb begin
    sh      = {rem_r[AREA_W-1:0], num_r[NUM_W-1]};
    num_nxt = {num_r[NUM_W-2:0], 1'b0};
    if (sh >= {1'b0, den_r}) begin
      rem_nxt = sh - {1'b0, den_r};
      q_nxt   = {q_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = sh;
      q_nxt   = {q_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    done <= rst_n && !start && busy_r && (cnt_r == CW'(1));
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      num_r  <= {pt, 14'd0};
      den_r  <= area;
      rem_r  <= '0;
      q_r    <= '0;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        if (den_r == '0 || q_nxt[NUM_W-1:RHO_W] != '0) dens <= RHO_MAX;
        else dens <= q_nxt[RHO_W-1:0];
      end
    end
  end
endmodule
